// ===== rtl/core/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants, types and the xorshift32 step of the cmwc generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

  // lag table depth, a power of two: the index is the low seed bits
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CARRY_TRIES = 256;
  localparam int unsigned TRY_W       = $clog2(CARRY_TRIES);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TRY_W-1:0]  try_t;

  localparam idx_t  IDX_LAST  = idx_t'(TABLE_DEPTH - 1);
  localparam try_t  TRY_LAST  = try_t'(CARRY_TRIES - 1);
  localparam word_t ZERO_SEED = 32'hBEEF57E2;

  // configuration register reset values
  localparam word_t MULT_RST  = 32'd18782;
  localparam word_t MASK_RST  = 32'hFFFFFFFE;
  localparam word_t LIMIT_RST = 32'd809430660;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARRY_LIMIT = 2'd2;

  // operation codes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    word_t data;
  } ram_wr_t;

  typedef struct packed {
    logic  vld;
    word_t word;
    word_t carry;
  } draw_res_t;

  function automatic word_t xs32(word_t v);
    word_t a;
    word_t b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ===== rtl/core/cmwc_ram.sv =====
// ----------------------------------------------------------------------------
// cmwc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cmwc_seed.sv =====
// ----------------------------------------------------------------------------
// cmwc_seed
// Reseed sequencer: fills the lag table with xorshift32 words, one per cycle,
// then searches for the initial carry.
// ----------------------------------------------------------------------------
module cmwc_seed (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cmwc_pkg::word_t   seed,
  input  cmwc_pkg::word_t   carry_limit,
  output cmwc_pkg::ram_wr_t wr,
  output logic              done,
  output cmwc_pkg::word_t   carry
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FILL  = 2'd1;
  localparam logic [1:0] S_CARRY = 2'd2;

  logic [1:0]      st_r, st_nxt;
  cmwc_pkg::word_t x_r, x_nxt;
  cmwc_pkg::idx_t  cnt_r, cnt_nxt;
  cmwc_pkg::try_t  tries_r, tries_nxt;
  logic            done_r, done_nxt;
  cmwc_pkg::word_t carry_r, carry_nxt;
  cmwc_pkg::word_t x_step;

  assign x_step = cmwc_pkg::xs32(x_r);

  always_comb begin
    st_nxt    = st_r;
    x_nxt     = x_r;
    cnt_nxt   = cnt_r;
    tries_nxt = tries_r;
    done_nxt  = 1'b0;
    carry_nxt = carry_r;
    wr.we     = 1'b0;
    wr.addr   = cnt_r;
    wr.data   = x_step;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          x_nxt   = (seed == '0) ? cmwc_pkg::ZERO_SEED : seed;
          cnt_nxt = '0;
          st_nxt  = S_FILL;
        end
      end
      S_FILL: begin
        wr.we   = 1'b1;
        x_nxt   = x_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == cmwc_pkg::IDX_LAST) begin
          tries_nxt = '0;
          st_nxt    = S_CARRY;
        end
      end
      S_CARRY: begin
        x_nxt = x_step;
        if (x_step <= carry_limit) begin
          carry_nxt = x_step;
          done_nxt  = 1'b1;
          st_nxt    = S_IDLE;
        end else if (tries_r == cmwc_pkg::TRY_LAST) begin
          // no word found, saturate to the limit
          carry_nxt = carry_limit;
          done_nxt  = 1'b1;
          st_nxt    = S_IDLE;
        end else begin
          tries_nxt = tries_r + 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    x_r     <= x_nxt;
    cnt_r   <= cnt_nxt;
    tries_r <= tries_nxt;
    carry_r <= carry_nxt;
  end

  assign done  = done_r;
  assign carry = carry_r;

endmodule

// ===== rtl/core/cmwc_draw.sv =====
// ----------------------------------------------------------------------------
// cmwc_draw
// Draw datapath: multiply the table entry, add the carry, then apply the
// wrap correction and the complement. The last stage holds until taken.
// ----------------------------------------------------------------------------
module cmwc_draw (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_vld,
  input  cmwc_pkg::word_t     rd_data,
  input  cmwc_pkg::word_t     multiplier,
  input  cmwc_pkg::word_t     result_mask,
  input  cmwc_pkg::word_t     carry,
  input  logic                take,
  output cmwc_pkg::draw_res_t res
);

  logic        v1_r, v2_r;
  logic [63:0] prod_r;
  logic [63:0] t_r;

  cmwc_pkg::word_t c_hi;
  cmwc_pkg::word_t x_sum;
  logic            wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= rd_vld;
      if (v1_r) begin
        v2_r <= 1'b1;
      end else if (take) begin
        v2_r <= 1'b0;
      end
    end
    if (rd_vld) begin
      prod_r <= 64'(multiplier) * 64'(rd_data);
    end
    if (v1_r) begin
      t_r <= prod_r + 64'(carry);
    end
  end

  assign c_hi  = t_r[63:32];
  assign x_sum = t_r[31:0] + c_hi;
  // 32-bit sum wrapped: bump both word and carry
  assign wrap  = (x_sum < c_hi);

  assign res.vld   = v2_r;
  assign res.word  = result_mask - (x_sum + 32'(wrap));
  assign res.carry = c_hi + 32'(wrap);

endmodule

// ===== rtl/core/cmwc_random_generator.sv =====
// ----------------------------------------------------------------------------
// cmwc_random_generator
// Complementary multiply-with-carry generator with a lag table in one RAM.
// ----------------------------------------------------------------------------
// draw: result through RAM read, multiply, carry add and output register;
//   one draw in flight, set by the carry chain: the next is accepted once it is taken
// reseed: start, table fill, carry search (at most CARRY_TRIES words), handoff;
//   no result; draws before the first reseed are taken and give none
// reset: synchronous, active low; clears control, index, carry and the seeded
//   flag and loads register defaults; the lag table is left as is
module cmwc_random_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [31:0]                      in_seed_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_random_word,
  input  logic                             cfg_we,
  input  logic [cmwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEED = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;

  logic [1:0]      st_r, st_nxt;
  cmwc_pkg::idx_t  idx_r, idx_nxt, idx_inc;
  cmwc_pkg::word_t carry_r, carry_nxt;
  logic            seeded_r, seeded_nxt;
  logic            out_valid_r, out_valid_nxt;
  cmwc_pkg::word_t out_word_r;
  cmwc_pkg::word_t mult_r, mask_r, limit_r;

  logic                accept;
  logic                seed_start;
  logic                rd_en;
  logic                take;
  cmwc_pkg::ram_wr_t   seed_wr;
  logic                seed_done;
  cmwc_pkg::word_t     seed_carry;
  cmwc_pkg::draw_res_t draw_res;
  cmwc_pkg::ram_wr_t   ram_wr;
  cmwc_pkg::word_t     ram_rdata;

  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_inc  = (idx_r == cmwc_pkg::IDX_LAST) ? '0 : idx_r + 1'b1;
  assign take     = (st_r == ST_DRAW) && draw_res.vld && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    carry_nxt  = carry_r;
    seeded_nxt = seeded_r;
    seed_start = 1'b0;
    rd_en      = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == cmwc_pkg::OP_RESEED) begin
            idx_nxt    = in_seed_value[cmwc_pkg::IDX_W-1:0];
            seed_start = 1'b1;
            st_nxt     = ST_SEED;
          end else if (seeded_r) begin
            idx_nxt = idx_inc;
            rd_en   = 1'b1;
            st_nxt  = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        if (seed_done) begin
          carry_nxt  = seed_carry;
          seeded_nxt = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      ST_DRAW: begin
        if (take) begin
          carry_nxt = draw_res.carry;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      idx_r       <= '0;
      carry_r     <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mult_r      <= cmwc_pkg::MULT_RST;
      mask_r      <= cmwc_pkg::MASK_RST;
      limit_r     <= cmwc_pkg::LIMIT_RST;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      carry_r     <= carry_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cmwc_pkg::REG_MULTIPLIER:  mult_r  <= cfg_wdata;
          cmwc_pkg::REG_RESULT_MASK: mask_r  <= cfg_wdata;
          cmwc_pkg::REG_CARRY_LIMIT: limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (take) begin
      out_word_r <= draw_res.word;
    end
  end

  // table writes: seed fill while seeding, else the draw write-back
  always_comb begin
    if (seed_wr.we) begin
      ram_wr = seed_wr;
    end else begin
      ram_wr.we   = take;
      ram_wr.addr = idx_r;
      ram_wr.data = draw_res.word;
    end
  end

  cmwc_ram #(
    .WIDTH (cmwc_pkg::WORD_W),
    .DEPTH (cmwc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (rd_en),
    .raddr (idx_inc),
    .rdata (ram_rdata)
  );

  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  cmwc_seed u_seed (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (seed_start),
    .seed        (in_seed_value),
    .carry_limit (limit_r),
    .wr          (seed_wr),
    .done        (seed_done),
    .carry       (seed_carry)
  );

  cmwc_draw u_draw (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_vld      (rd_vld_r),
    .rd_data     (ram_rdata),
    .multiplier  (mult_r),
    .result_mask (mask_r),
    .carry       (carry_r),
    .take        (take),
    .res         (draw_res)
  );

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule
